// File: sv/tepq_pkg.sv
// Shared types, sizes and codes for the timed event priority queue.
package tepq_pkg;

  // Store sizes and field widths.
  localparam int QUEUE_DEPTH   = 64;
  localparam int TRIGGER_DEPTH = 16;
  localparam int ID_BITS       = 10;
  localparam int ID_W          = 10;
  localparam int TIME_W        = 64;
  localparam int CMD_W         = 3;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 3;

  localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int T_CNT_W = $clog2(TRIGGER_DEPTH + 1);
  localparam int T_IDX_W = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE   = 3'd0,
    CMD_CANCEL_SRC = 3'd1,
    CMD_CANCEL_AT  = 3'd2,
    CMD_RESCHEDULE = 3'd3,
    CMD_PUSH       = 3'd4,
    CMD_POP        = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_QUEUE_FULL = 3'd1,
    ST_PAST       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TRIG_FULL  = 3'd4
  } status_t;

  // Kind of item a pop returned.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_TIMED   = 2'd2
  } kind_t;

  // Data movement of one queue cell.
  typedef enum logic [1:0] {
    MV_HOLD       = 2'd0,
    MV_FROM_RIGHT = 2'd1,
    MV_FROM_LEFT  = 2'd2,
    MV_LOAD       = 2'd3
  } move_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_CMP    = 3'd1,
    S_EXEC   = 3'd2,
    S_RECMP  = 3'd3,
    S_INSERT = 3'd4,
    S_OUT    = 3'd5
  } state_t;

  // Control sent to each cell.
  typedef struct packed {
    logic  cmp_en;
    move_t move;
  } cell_ctrl_t;

  // Compare results held by each cell.
  typedef struct packed {
    logic le;
    logic src_eq;
    logic both_eq;
  } cell_flags_t;

  // One queue entry.
  typedef struct packed {
    logic [TIME_W-1:0]  tstamp;
    logic [ID_BITS-1:0] src;
  } cell_data_t;

endpackage

// File: sv/tepq_if.sv
// Handshake channels for command words and result words.
interface tepq_cmd_if import tepq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   item_id;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, output command, output item_id, output event_time,
                  input ready);
  modport sink (input valid, input command, input item_id, input event_time,
                output ready);
endinterface

interface tepq_res_if import tepq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   popped_kind;
  logic [ID_W-1:0]     popped_id;
  logic [TIME_W-1:0]   popped_time;
  logic [STATUS_W-1:0] status;
  logic                dropped_late;

  modport source (output valid, output popped_kind, output popped_id, output popped_time,
                  output status, output dropped_late, input ready);
  modport sink (input valid, input popped_kind, input popped_id, input popped_time,
                input status, input dropped_late, output ready);
endinterface

// File: sv/tepq_cell.sv
// One cell of the sorted queue chain: holds an entry, compares it, shifts it.
module tepq_cell import tepq_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               in_range,
  input  logic [TIME_W-1:0]  key_time,
  input  logic [ID_BITS-1:0] key_id,
  input  cell_data_t         left_data,
  input  cell_data_t         right_data,
  output cell_data_t         data,
  output cell_flags_t        flags
);

  // Compare the held entry against the command key.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flags.le      <= in_range && (data.tstamp <= key_time);
      flags.src_eq  <= in_range && (data.src == key_id);
      flags.both_eq <= in_range && (data.src == key_id) && (data.tstamp == key_time);
    end
  end

  // Move data along the chain or take the new entry.
  always_ff @(posedge clk) begin
    unique case (ctrl.move)
      MV_HOLD:       data <= data;
      MV_FROM_RIGHT: data <= right_data;
      MV_FROM_LEFT:  data <= left_data;
      MV_LOAD:       data <= '{tstamp: key_time, src: key_id};
      default:       data <= data;
    endcase
  end

endmodule

// File: sv/timed_event_priority_queue.sv
// Timed event priority queue with trigger stack, built on a chain of sorted cells.
// A command steps through compare, execute and output load, then returns to idle.
// A reschedule that is neither past nor late adds a recompare and an insert step.
// The output load step puts the result word into the output register and waits while
// a held result word is not taken. The sequencer runs one command at a time.
// Reset (synchronous, active high) empties both stores and clears end_time and the last
// event time; entry storage is not cleared, no clearing pass is needed.
module timed_event_priority_queue import tepq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tepq_cmd_if.sink          cmd_ch,
  tepq_res_if.source        res_ch,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  state_t              state, state_next;
  logic [TIME_W-1:0]   end_time;
  logic [TIME_W-1:0]   last_event_time, last_event_time_next;
  logic [Q_CNT_W-1:0]  q_count, q_count_next;
  logic [T_CNT_W-1:0]  t_count, t_count_next;
  logic [T_CNT_W-1:0]  t_top;
  logic [ID_BITS-1:0]  trig_stack [TRIGGER_DEPTH];

  // Latched command word.
  logic [CMD_W-1:0]    cmd_q;
  logic [ID_BITS-1:0]  id_q;
  logic [TIME_W-1:0]   t_q;
  logic                past_q, late_q;

  // Pending result and output register.
  kind_t               res_kind, res_kind_next;
  logic [ID_W-1:0]     res_id, res_id_next;
  status_t             res_status, res_status_next;
  logic                res_late, res_late_next;
  logic                load_out;
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [ID_W-1:0]     out_id;
  logic [TIME_W-1:0]   out_time;
  logic [STATUS_W-1:0] out_status;
  logic                out_late;

  // Cell chain signals.
  cell_data_t          cell_out [QUEUE_DEPTH];
  cell_flags_t         cell_flg [QUEUE_DEPTH];
  cell_ctrl_t          cell_ctl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le_v, src_v, both_v, sel_v, first_v, ge_v;
  logic                any_match;
  logic                del_en, ins_en, shift_all, push_en, cmp_en;
  logic                q_full, t_full;

  assign cmd_ch.ready = (state == S_IDLE);
  assign q_full  = (q_count >= Q_CNT_W'(QUEUE_DEPTH));
  assign t_full  = (t_count >= T_CNT_W'(TRIGGER_DEPTH));
  assign t_top   = t_count - 1'b1;
  assign cmp_en  = (state == S_CMP) || (state == S_RECMP);

  // First matching entry and the cells at or above it.
  assign sel_v     = (cmd_q == CMD_CANCEL_AT) ? both_v : src_v;
  assign first_v   = sel_v & (~sel_v + 1'b1);
  assign ge_v      = ~first_v + 1'b1;
  assign any_match = |sel_v;

  // The chain of cells with per-cell movement control.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic       le_prev;
    logic       in_range;
    cell_data_t left_d, right_d;

    assign le_v[k]   = cell_flg[k].le;
    assign src_v[k]  = cell_flg[k].src_eq;
    assign both_v[k] = cell_flg[k].both_eq;
    assign in_range  = (Q_CNT_W'(k) < q_count);

    if (k == 0) begin : g_first
      assign le_prev = 1'b1;
      assign left_d  = cell_out[k];
    end else begin : g_mid
      assign le_prev = le_v[k-1];
      assign left_d  = cell_out[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right_d = cell_out[k];
    end else begin : g_inner
      assign right_d = cell_out[k+1];
    end

    // Insert opens a slot at the first later entry; delete closes the gap.
    always_comb begin
      cell_ctl[k].cmp_en = cmp_en;
      priority if (ins_en && !le_v[k] && le_prev) begin
        cell_ctl[k].move = MV_LOAD;
      end else if (ins_en && !le_v[k]) begin
        cell_ctl[k].move = MV_FROM_LEFT;
      end else if (shift_all || (del_en && ge_v[k])) begin
        cell_ctl[k].move = MV_FROM_RIGHT;
      end else begin
        cell_ctl[k].move = MV_HOLD;
      end
    end

    tepq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctl[k]),
      .in_range   (in_range),
      .key_time   (t_q),
      .key_id     (id_q),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_out[k]),
      .flags      (cell_flg[k])
    );
  end

  // Sequencer: next state, store updates and result.
  always_comb begin
    state_next           = state;
    del_en               = 1'b0;
    ins_en               = 1'b0;
    shift_all            = 1'b0;
    push_en              = 1'b0;
    load_out             = 1'b0;
    q_count_next         = q_count;
    t_count_next         = t_count;
    last_event_time_next = last_event_time;
    res_kind_next        = res_kind;
    res_id_next          = res_id;
    res_status_next      = res_status;
    res_late_next        = res_late;
    unique case (state)
      S_IDLE: begin
        if (cmd_ch.valid) begin
          state_next      = S_CMP;
          res_kind_next   = KIND_NONE;
          res_id_next     = '0;
          res_status_next = ST_OK;
          res_late_next   = 1'b0;
        end
      end
      S_CMP: state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_OUT;
        unique case (cmd_q)
          CMD_SCHEDULE: begin
            priority if (past_q) begin
              res_status_next = ST_PAST;
            end else if (late_q) begin
              res_late_next = 1'b1;
            end else if (q_full) begin
              res_status_next = ST_QUEUE_FULL;
            end else begin
              ins_en       = 1'b1;
              q_count_next = q_count + 1'b1;
            end
          end
          CMD_CANCEL_SRC: begin
            if (any_match) begin
              del_en       = 1'b1;
              q_count_next = q_count - 1'b1;
            end
          end
          CMD_CANCEL_AT: begin
            if (any_match) begin
              del_en       = 1'b1;
              q_count_next = q_count - 1'b1;
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end
          CMD_RESCHEDULE: begin
            if (past_q) begin
              res_status_next = ST_PAST;
            end else begin
              if (any_match) begin
                del_en       = 1'b1;
                q_count_next = q_count - 1'b1;
              end
              if (late_q) begin
                res_late_next = 1'b1;
              end else begin
                state_next = S_RECMP;
              end
            end
          end
          CMD_PUSH: begin
            if (t_full) begin
              res_status_next = ST_TRIG_FULL;
            end else begin
              push_en      = 1'b1;
              t_count_next = t_count + 1'b1;
            end
          end
          CMD_POP: begin
            priority if (t_count != '0) begin
              res_kind_next = KIND_TRIGGER;
              res_id_next   = ID_W'(trig_stack[t_top[T_IDX_W-1:0]]);
              t_count_next  = t_top;
            end else if (q_count != '0) begin
              res_kind_next        = KIND_TIMED;
              res_id_next          = ID_W'(cell_out[0].src);
              last_event_time_next = cell_out[0].tstamp;
              shift_all            = 1'b1;
              q_count_next         = q_count - 1'b1;
            end else begin
              res_kind_next = KIND_NONE;
            end
          end
          default: ;
        endcase
      end
      S_RECMP: state_next = S_INSERT;
      S_INSERT: begin
        state_next = S_OUT;
        if (q_full) begin
          res_status_next = ST_QUEUE_FULL;
        end else begin
          ins_en       = 1'b1;
          q_count_next = q_count + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid || res_ch.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      q_count         <= '0;
      t_count         <= '0;
      last_event_time <= '0;
      end_time        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      q_count         <= q_count_next;
      t_count         <= t_count_next;
      last_event_time <= last_event_time_next;
      if (cfg_wr_en) begin
        end_time <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture, time checks and result payload.
  always_ff @(posedge clk) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      cmd_q <= cmd_ch.command;
      id_q  <= ID_BITS'(cmd_ch.item_id);
      t_q   <= cmd_ch.event_time;
    end
    past_q     <= (t_q < last_event_time);
    late_q     <= (end_time != '0) && (t_q >= end_time);
    res_kind   <= res_kind_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    res_late   <= res_late_next;
    if (load_out) begin
      out_kind   <= res_kind;
      out_id     <= res_id;
      out_time   <= last_event_time;
      out_status <= res_status;
      out_late   <= res_late;
    end
  end

  // Trigger stack storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      trig_stack[t_count[T_IDX_W-1:0]] <= id_q;
    end
  end

  assign res_ch.valid        = out_valid;
  assign res_ch.popped_kind  = out_kind;
  assign res_ch.popped_id    = out_id;
  assign res_ch.popped_time  = out_time;
  assign res_ch.status       = out_status;
  assign res_ch.dropped_late = out_late;

  // The queue never holds more than its depth.
  a_q_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // The trigger stack never holds more than its depth.
  a_t_count_bound: assert property (@(posedge clk) disable iff (rst)
    t_count <= T_CNT_W'(TRIGGER_DEPTH))
    else $error("trigger count exceeds depth");

  // The queue fill changes only in the execute and insert steps.
  a_q_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && state != S_INSERT) |=> $stable(q_count))
    else $error("queue count changed outside execute or insert");

  // Popping the earliest entry never moves the last event time backward.
  a_last_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (last_event_time >= $past(last_event_time)))
    else $error("last event time moved backward");

endmodule

// File: bench/tb.sv
// Testbench for the timed event priority queue: directed and random commands checked by a mirror.
`timescale 1ns / 1ps

module tb;
  import tepq_pkg::*;

  // Command codes with no operation behind them.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 10;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_TRIG, MIX_BAL} traffic_t;

  // One result word as the block should return it.
  typedef struct {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ptime;
    status_t           status;
    logic              late;
  } queue_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;

  tepq_cmd_if cmd_ch ();
  tepq_res_if res_ch ();

  timed_event_priority_queue dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_ch      (cmd_ch),
    .res_ch      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Mirror of the block state.
  cell_data_t        mirror_entries[$];
  logic [ID_W-1:0]   mirror_triggers[$];
  logic [TIME_W-1:0] mirror_last_time;
  logic [TIME_W-1:0] mirror_end_time;

  queue_result_t awaited_results[$];
  int fail_count;
  int result_count;
  int cycle_count;
  int hold_left;
  int sink_stall;
  bit src_idling;
  bit sink_idling;

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] s;
    s = a + b;
    if (s < a) s = '1;
    return s;
  endfunction

  function automatic bit is_late(logic [TIME_W-1:0] t);
    return mirror_end_time != 0 && t >= mirror_end_time;
  endfunction

  // Sorted insert; equal times go behind the ones already queued.
  function automatic void mirror_insert(logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    int pos;
    cell_data_t e;
    pos = 0;
    e.tstamp = t;
    e.src = id;
    while (pos < mirror_entries.size() && mirror_entries[pos].tstamp <= t) pos++;
    mirror_entries.insert(pos, e);
  endfunction

  function automatic void mirror_cancel_first(logic [ID_W-1:0] id);
    for (int k = 0; k < mirror_entries.size(); k++) begin
      if (mirror_entries[k].src == id) begin
        mirror_entries.delete(k);
        return;
      end
    end
  endfunction

  // Runs one command on the mirror and returns the word the block should send back.
  function automatic queue_result_t predict_queue_result(logic [CMD_W-1:0] cmd,
                                                         logic [ID_W-1:0] id,
                                                         logic [TIME_W-1:0] t);
    queue_result_t r;
    bit found;
    r.kind = KIND_NONE;
    r.id = '0;
    r.status = ST_OK;
    r.late = 1'b0;
    found = 0;
    case (cmd)
      CMD_SCHEDULE: begin
        if (t < mirror_last_time) r.status = ST_PAST;
        else if (is_late(t)) r.late = 1'b1;
        else if (mirror_entries.size() >= QUEUE_DEPTH) r.status = ST_QUEUE_FULL;
        else mirror_insert(id, t);
      end
      CMD_CANCEL_SRC: mirror_cancel_first(id);
      CMD_CANCEL_AT: begin
        for (int k = 0; k < mirror_entries.size() && !found; k++) begin
          if (mirror_entries[k].tstamp == t && mirror_entries[k].src == id) begin
            mirror_entries.delete(k);
            found = 1;
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      CMD_RESCHEDULE: begin
        if (t < mirror_last_time) begin
          r.status = ST_PAST;
        end else begin
          mirror_cancel_first(id);
          if (is_late(t)) r.late = 1'b1;
          else if (mirror_entries.size() >= QUEUE_DEPTH) r.status = ST_QUEUE_FULL;
          else mirror_insert(id, t);
        end
      end
      CMD_PUSH: begin
        if (mirror_triggers.size() >= TRIGGER_DEPTH) r.status = ST_TRIG_FULL;
        else mirror_triggers.insert(mirror_triggers.size(), id);
      end
      CMD_POP: begin
        if (mirror_triggers.size() > 0) begin
          r.kind = KIND_TRIGGER;
          r.id = mirror_triggers[mirror_triggers.size() - 1];
          mirror_triggers.delete(mirror_triggers.size() - 1);
        end else if (mirror_entries.size() > 0) begin
          r.kind = KIND_TIMED;
          r.id = mirror_entries[0].src;
          mirror_last_time = mirror_entries[0].tstamp;
          void'(mirror_entries.pop_front());
        end
      end
      default: ;
    endcase
    r.ptime = mirror_last_time;
    return r;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ID_W'($urandom_range(0, 5));
    if (r < 78) return 10'd1023;
    return ID_W'($urandom_range(0, 1023));
  endfunction

  // Times cluster around the last event time and the end time to hit the edges.
  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    logic [TIME_W-1:0] d;
    r = $urandom_range(0, 99);
    if (r < 50) return sat_add(mirror_last_time, TIME_W'($urandom_range(0, 200)));
    if (r < 60) return mirror_last_time;
    if (r < 70) begin
      d = TIME_W'($urandom_range(1, 50));
      return (mirror_last_time >= d) ? mirror_last_time - d : '0;
    end
    if (r < 85) begin
      if (mirror_end_time == 0)
        return sat_add(mirror_last_time, TIME_W'($urandom_range(200, 5000)));
      return sat_add((mirror_end_time >= 2) ? mirror_end_time - 2 : '0,
                     TIME_W'($urandom_range(0, 4)));
    end
    if (r < 98) return sat_add(mirror_last_time, TIME_W'($urandom_range(0, 100000)));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(traffic_t mix);
    int r;
    int w_sched, w_resch, w_csrc, w_cat, w_push, w_pop;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin w_sched = 50; w_resch = 15; w_csrc = 7;  w_cat = 7;  w_push = 8;  w_pop = 10; end
      MIX_DRAIN: begin w_sched = 10; w_resch = 5;  w_csrc = 5;  w_cat = 5;  w_push = 5;  w_pop = 68; end
      MIX_TRIG:  begin w_sched = 10; w_resch = 5;  w_csrc = 5;  w_cat = 5;  w_push = 58; w_pop = 15; end
      default:   begin w_sched = 30; w_resch = 15; w_csrc = 10; w_cat = 12; w_push = 13; w_pop = 18; end
    endcase
    if (r < w_sched) return CMD_SCHEDULE;
    r -= w_sched;
    if (r < w_resch) return CMD_RESCHEDULE;
    r -= w_resch;
    if (r < w_csrc) return CMD_CANCEL_SRC;
    r -= w_csrc;
    if (r < w_cat) return CMD_CANCEL_AT;
    r -= w_cat;
    if (r < w_push) return CMD_PUSH;
    r -= w_push;
    if (r < w_pop) return CMD_POP;
    return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
  endfunction

  // Offers one command word and records its expected result once accepted.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t);
    int gap;
    @(negedge clk);
    cmd_ch.valid = 1'b1;
    cmd_ch.command = cmd;
    cmd_ch.item_id = id;
    cmd_ch.event_time = t;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    awaited_results.insert(awaited_results.size(), predict_queue_result(cmd, id, t));
    gap = (src_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random word; cancels and reschedules often aim at entries that exist.
  task automatic send_random(input traffic_t mix);
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] t;
    int k;
    cmd = pick_command(mix);
    id = pick_id();
    t = pick_time();
    if ((cmd == CMD_CANCEL_AT || cmd == CMD_CANCEL_SRC || cmd == CMD_RESCHEDULE) &&
        mirror_entries.size() > 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, mirror_entries.size() - 1);
      id = mirror_entries[k].src;
      if (cmd != CMD_RESCHEDULE) t = mirror_entries[k].tstamp;
    end
    send_word(cmd, id, t);
  endtask

  // Stops offering words and waits until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_end_time(input logic [TIME_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mirror_end_time = value;
  endtask

  // Every command at least once, empty stores, equal times, past times and spare codes.
  task automatic test_basic_commands();
    src_idling = 1;
    sink_idling = 1;
    send_word(CMD_POP, 10'd0, '0);
    send_word(CMD_CANCEL_SRC, 10'd5, '0);
    send_word(CMD_CANCEL_AT, 10'd5, 64'd100);
    send_word(CMD_SCHEDULE, 10'd1023, '1);
    send_word(CMD_SCHEDULE, 10'd0, '0);
    send_word(CMD_SCHEDULE, 10'd3, 64'd100);
    send_word(CMD_SCHEDULE, 10'd4, 64'd100);
    send_word(CMD_CANCEL_AT, 10'd1023, '1);
    send_word(CMD_RESCHEDULE, 10'd3, 64'd50);
    send_word(CMD_PUSH, 10'd1023, '0);
    send_word(CMD_PUSH, 10'd0, '1);
    repeat (4) send_word(CMD_POP, 10'd0, '0);
    send_word(CMD_SCHEDULE, 10'd7, 64'd10);
    send_word(CMD_RESCHEDULE, 10'd4, 64'd20);
    send_word(CMD_SPARE_6, 10'd1023, '1);
    send_word(CMD_SPARE_7, 10'd0, '0);
    send_word(CMD_CANCEL_SRC, 10'd4, '0);
    send_word(CMD_POP, 10'd0, '0);
  endtask

  // Schedules at and beyond the end time are dropped; a reschedule still cancels.
  task automatic test_end_time_limit();
    write_end_time(64'd1000);
    send_word(CMD_SCHEDULE, 10'd8, 64'd999);
    send_word(CMD_SCHEDULE, 10'd8, 64'd1000);
    send_word(CMD_SCHEDULE, 10'd9, '1);
    send_word(CMD_RESCHEDULE, 10'd8, 64'd1500);
    send_word(CMD_CANCEL_SRC, 10'd8, '0);
    send_word(CMD_SCHEDULE, 10'd9, 64'd40);
    send_word(CMD_POP, 10'd0, '0);
  endtask

  // Fills the trigger stack and the queue past their depths, then drains both.
  task automatic test_store_limits();
    write_end_time('0);
    src_idling = 0;
    sink_idling = 0;
    for (int i = 0; i <= TRIGGER_DEPTH; i++)
      send_word(CMD_PUSH, ID_W'($urandom_range(0, 1023)), {$urandom, $urandom});
    for (int i = 0; i <= TRIGGER_DEPTH; i++) send_word(CMD_POP, pick_id(), '0);
    src_idling = 1;
    sink_idling = 1;
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_word(CMD_SCHEDULE, ID_W'($urandom_range(0, 7)),
                sat_add(mirror_last_time, TIME_W'($urandom_range(0, 500))));
    // A reschedule on a full queue succeeds only when it frees a slot.
    send_word(CMD_RESCHEDULE, mirror_entries[$urandom_range(0, QUEUE_DEPTH - 1)].src,
              sat_add(mirror_last_time, TIME_W'($urandom_range(0, 500))));
    send_word(CMD_RESCHEDULE, 10'd1000, sat_add(mirror_last_time, 10));
    send_word(CMD_SCHEDULE, 10'd1, sat_add(mirror_last_time, 20));
    for (int i = 0; i <= QUEUE_DEPTH; i++) send_word(CMD_POP, pick_id(), '0);
  endtask

  // The receiver holds off while the sender keeps offering words.
  task automatic test_stall_pressure();
    settle();
    @(posedge clk);
    hold_left = 400;
    src_idling = 0;
    repeat (30) send_random(MIX_BAL);
    settle();
    src_idling = 1;
  endtask

  // Random traffic in segments under several end time settings.
  task automatic test_random_traffic();
    int budget;
    int seg;
    logic [TIME_W-1:0] limit;
    traffic_t mix;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: limit = '0;
        1: limit = sat_add(mirror_last_time, 400);
        2: limit = '1;
        3: limit = sat_add(mirror_last_time, 150);
        4: limit = 64'd1;
        default: limit = '0;
      endcase
      write_end_time(limit);
      budget = (p == 4) ? 60 : 230;
      while (budget > 0) begin
        mix = traffic_t'($urandom_range(0, 3));
        seg = $urandom_range(20, 100);
        if (seg > budget) seg = budget;
        src_idling = $urandom_range(0, 3) != 0;
        sink_idling = $urandom_range(0, 3) != 0;
        repeat (seg) send_random(mix);
        budget -= seg;
      end
    end
  endtask

  // Receiver: random stalls plus the long hold-off when one is requested.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else if (sink_stall > 0) begin
        res_ch.ready = 1'b0;
        sink_stall--;
      end else begin
        res_ch.ready = 1'b1;
        if (sink_idling && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
      end
    end
  end

  // Compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      result_count++;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing expected", result_count);
      end else begin
        want = awaited_results.pop_front();
        if (res_ch.popped_kind !== want.kind || res_ch.popped_id !== want.id ||
            res_ch.popped_time !== want.ptime || res_ch.status !== want.status ||
            res_ch.dropped_late !== want.late) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: expected kind %0d id %0d time %0d status %0d late %0b, %s",
                     result_count, want.kind, want.id, want.ptime, want.status, want.late,
                     $sformatf("got kind %0d id %0d time %0d status %0d late %0b",
                               res_ch.popped_kind, res_ch.popped_id, res_ch.popped_time,
                               res_ch.status, res_ch.dropped_late));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_SCHEDULE;
    cmd_ch.item_id = '0;
    cmd_ch.event_time = '0;
    mirror_last_time = '0;
    mirror_end_time = '0;
    fail_count = 0;
    result_count = 0;
    cycle_count = 0;
    hold_left = 0;
    sink_stall = 0;
    src_idling = 1;
    sink_idling = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_commands();
    test_end_time_limit();
    test_store_limits();
    test_stall_pressure();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
